// ----- rtl/window_history_min_max_tracker_top_assert.svh -----
// Assertion macros shared by the tracker RTL.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef WINDOW_HISTORY_MIN_MAX_TRACKER_TOP_ASSERT_SVH
`define WINDOW_HISTORY_MIN_MAX_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTH

// The consequence must hold in the same cycle as the condition.
`define WHT_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("tracker check failed");

// The consequence must hold in the cycle after the condition.
`define WHT_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("tracker check failed");

`else

`define WHT_ASSERT_SAME(label, clk, rstn, cond, cons)
`define WHT_ASSERT_NEXT(label, clk, rstn, cond, cons)

`endif

`endif

// ----- rtl/wht_pkg.sv -----
package wht_pkg;

    // Command codes carried on the mode field.
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_APPEND    = 3'd0;
    localparam mode_t MODE_TRACK     = 3'd1;
    localparam mode_t MODE_RECOMPUTE = 3'd2;
    localparam mode_t MODE_CLEAR     = 3'd3;
    localparam mode_t MODE_READ      = 3'd4;

endpackage

// ----- rtl/window_history_min_max_tracker_top.sv -----
// Sliding-window min/max tracker over signed Q8.8 samples. One command is taken per beat and
// answered by exactly one result beat carrying the status after the command. The block takes a
// new command only while its sequencer is idle, and a command can be taken while the previous
// result still waits on the output register. Append, clear, read and the unused codes go from
// the input beat through the emit state to the output register; track first passes the fold-view
// state because the one shared compare unit folds the sample into the all-time bounds and then
// into the view bounds; recompute of a non-empty window scans first, as the window memory
// is read one entry per cycle through its single registered read port while the same compare
// unit folds each entry in. The window memory has no reset; entries are only ever used once written.
module window_history_min_max_tracker_top
    import wht_pkg::*;
#(
    parameter int WINDOW_DEPTH = 128,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [2:0]                             s_mode,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]        s_read_index,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_view_min,
    output logic signed [SAMPLE_BITS-1:0]          m_view_max,
    output logic                                   m_view_valid,
    output logic signed [SAMPLE_BITS-1:0]          m_total_min,
    output logic signed [SAMPLE_BITS-1:0]          m_total_max,
    output logic                                   m_total_valid,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]      m_stored_count,
    output logic signed [SAMPLE_BITS-1:0]          m_entry_value
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(WINDOW_DEPTH - 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_FOLD_VIEW = 2'd1;
    localparam logic [1:0] ST_SCAN      = 2'd2;
    localparam logic [1:0] ST_EMIT      = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [AW-1:0]                oldest_reg, oldest_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] total_lo_reg, total_lo_next;
    logic signed [SAMPLE_BITS-1:0] total_hi_reg, total_hi_next;
    logic                         total_seen_reg, total_seen_next;
    logic signed [SAMPLE_BITS-1:0] view_lo_reg, view_lo_next;
    logic signed [SAMPLE_BITS-1:0] view_hi_reg, view_hi_next;
    logic                         view_seen_reg, view_seen_next;
    logic [AW-1:0]                scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]                scan_cnt_reg, scan_cnt_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                         read_hit_reg, read_hit_next;
    logic                         m_valid_reg, m_valid_next;

    logic signed [SAMPLE_BITS-1:0] out_view_lo_reg, out_view_hi_reg;
    logic signed [SAMPLE_BITS-1:0] out_total_lo_reg, out_total_hi_reg;
    logic signed [SAMPLE_BITS-1:0] out_entry_reg;
    logic                         out_view_seen_reg, out_total_seen_reg;
    logic [CW-1:0]                out_count_reg;

    logic                         s_accept;
    logic                         emit_load;

    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic signed [SAMPLE_BITS-1:0] mem_rdata;

    logic signed [SAMPLE_BITS-1:0] unit_lo_in, unit_hi_in, unit_val;
    logic                         unit_seen_in;
    logic signed [SAMPLE_BITS-1:0] unit_lo_out, unit_hi_out;

    // Ring index arithmetic: both operands are below the depth, so one subtract wraps.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_A) ? '0 : a + 1'b1;
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    wht_window_mem #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (s_sample),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Operand selection for the shared compare unit.
    always_comb begin
        case (state_reg)
            ST_FOLD_VIEW: begin
                unit_lo_in   = view_lo_reg;
                unit_hi_in   = view_hi_reg;
                unit_seen_in = view_seen_reg;
                unit_val     = sample_reg;
            end
            ST_SCAN: begin
                unit_lo_in   = view_lo_reg;
                unit_hi_in   = view_hi_reg;
                unit_seen_in = (scan_cnt_reg != '0);
                unit_val     = mem_rdata;
            end
            default: begin
                unit_lo_in   = total_lo_reg;
                unit_hi_in   = total_hi_reg;
                unit_seen_in = total_seen_reg;
                unit_val     = s_sample;
            end
        endcase
    end

    wht_fold_unit #(
        .WIDTH (SAMPLE_BITS)
    ) u_fold (
        .cur_lo   (unit_lo_in),
        .cur_hi   (unit_hi_in),
        .cur_seen (unit_seen_in),
        .value    (unit_val),
        .next_lo  (unit_lo_out),
        .next_hi  (unit_hi_out)
    );

    // Sequencer and state updates.
    always_comb begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        total_lo_next   = total_lo_reg;
        total_hi_next   = total_hi_reg;
        total_seen_next = total_seen_reg;
        view_lo_next    = view_lo_reg;
        view_hi_next    = view_hi_reg;
        view_seen_next  = view_seen_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_cnt_next   = scan_cnt_reg;
        sample_next     = sample_reg;
        read_hit_next   = read_hit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        emit_load       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = oldest_reg;
        mem_re          = 1'b0;
        mem_raddr       = oldest_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next   = s_sample;
                    read_hit_next = 1'b0;
                    state_next    = ST_EMIT;
                    case (s_mode)
                        MODE_APPEND: begin
                            mem_we = 1'b1;
                            if (count_reg < DEPTH_C) begin
                                mem_waddr  = wrap_add(oldest_reg, count_reg[AW-1:0]);
                                count_next = count_reg + 1'b1;
                            end else begin
                                mem_waddr   = oldest_reg;
                                oldest_next = wrap_inc(oldest_reg);
                            end
                        end
                        MODE_TRACK: begin
                            total_lo_next   = unit_lo_out;
                            total_hi_next   = unit_hi_out;
                            total_seen_next = 1'b1;
                            state_next      = ST_FOLD_VIEW;
                        end
                        MODE_RECOMPUTE: begin
                            if (count_reg != '0) begin
                                mem_re        = 1'b1;
                                mem_raddr     = oldest_reg;
                                scan_ptr_next = wrap_inc(oldest_reg);
                                scan_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            oldest_next     = '0;
                            count_next      = '0;
                            total_lo_next   = '0;
                            total_hi_next   = '0;
                            total_seen_next = 1'b0;
                            view_lo_next    = '0;
                            view_hi_next    = '0;
                            view_seen_next  = 1'b0;
                        end
                        MODE_READ: begin
                            if (CW'(s_read_index) < count_reg) begin
                                mem_re        = 1'b1;
                                mem_raddr     = wrap_add(oldest_reg, s_read_index);
                                read_hit_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FOLD_VIEW: begin
                view_lo_next   = unit_lo_out;
                view_hi_next   = unit_hi_out;
                view_seen_next = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_SCAN: begin
                // Fold the entry read last cycle and fetch the next one.
                mem_re         = 1'b1;
                mem_raddr      = scan_ptr_reg;
                scan_ptr_next  = wrap_inc(scan_ptr_reg);
                scan_cnt_next  = scan_cnt_reg + 1'b1;
                view_lo_next   = unit_lo_out;
                view_hi_next   = unit_hi_out;
                view_seen_next = 1'b1;
                if ((scan_cnt_reg + 1'b1) == count_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    emit_load    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and tracker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            oldest_reg     <= '0;
            count_reg      <= '0;
            total_lo_reg   <= '0;
            total_hi_reg   <= '0;
            total_seen_reg <= 1'b0;
            view_lo_reg    <= '0;
            view_hi_reg    <= '0;
            view_seen_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            read_hit_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            total_lo_reg   <= total_lo_next;
            total_hi_reg   <= total_hi_next;
            total_seen_reg <= total_seen_next;
            view_lo_reg    <= view_lo_next;
            view_hi_reg    <= view_hi_next;
            view_seen_reg  <= view_seen_next;
            scan_cnt_reg   <= scan_cnt_next;
            read_hit_reg   <= read_hit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        scan_ptr_reg <= scan_ptr_next;
        sample_reg   <= sample_next;
    end

    // Output register for the result beat.
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            out_view_lo_reg    <= view_lo_reg;
            out_view_hi_reg    <= view_hi_reg;
            out_view_seen_reg  <= view_seen_reg;
            out_total_lo_reg   <= total_lo_reg;
            out_total_hi_reg   <= total_hi_reg;
            out_total_seen_reg <= total_seen_reg;
            out_count_reg      <= count_reg;
            out_entry_reg      <= read_hit_reg ? mem_rdata : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_view_min     = out_view_lo_reg;
    assign m_view_max     = out_view_hi_reg;
    assign m_view_valid   = out_view_seen_reg;
    assign m_total_min    = out_total_lo_reg;
    assign m_total_max    = out_total_hi_reg;
    assign m_total_valid  = out_total_seen_reg;
    assign m_stored_count = out_count_reg;
    assign m_entry_value  = out_entry_reg;

    `include "window_history_min_max_tracker_top_assert.svh"

    // The oldest pointer only moves once the window has filled up.
    `WHT_ASSERT_SAME(a_oldest_when_full, aclk, aresetn, oldest_reg != '0, count_reg == DEPTH_C)

    // The fill count never passes the window depth.
    `WHT_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_C)

    // A scan never runs past the stored samples.
    `WHT_ASSERT_SAME(a_scan_bound, aclk, aresetn, state_reg == ST_SCAN, scan_cnt_reg < count_reg)

    // Window occupancy changes only on an accepted command.
    `WHT_ASSERT_NEXT(a_count_stable, aclk, aresetn, !s_accept, $stable(count_reg))

    // A clear leaves the window empty and both trackers invalid.
    `WHT_ASSERT_NEXT(a_clear_effect, aclk, aresetn, s_accept && (s_mode == MODE_CLEAR), (count_reg == '0) && !total_seen_reg && !view_seen_reg)

endmodule

// ----- rtl/wht_window_mem.sv -----
module wht_window_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/wht_fold_unit.sv -----
module wht_fold_unit #(
    parameter int WIDTH = 16
) (
    input  logic signed [WIDTH-1:0] cur_lo,
    input  logic signed [WIDTH-1:0] cur_hi,
    input  logic                    cur_seen,
    input  logic signed [WIDTH-1:0] value,
    output logic signed [WIDTH-1:0] next_lo,
    output logic signed [WIDTH-1:0] next_hi
);

    // A tracker that holds no sample takes the value as both bounds;
    // otherwise each bound moves only if the value lies beyond it.
    always_comb begin
        if (!cur_seen) begin
            next_lo = value;
            next_hi = value;
        end else begin
            next_lo = (value < cur_lo) ? value : cur_lo;
            next_hi = (value > cur_hi) ? value : cur_hi;
        end
    end

endmodule
